[sv/ppid_pkg.sv]
// shared types, constants and helpers for the position pid block
// no dependencies; imported by every module of the block
package ppid_pkg;

  // 2*pi/60 in q16.16, turns rpm into rad/s
  localparam logic [31:0] RadPerRpm = 32'd6863;

  typedef struct packed {
    logic signed [31:0] pos_setpoint;
    logic signed [31:0] measured_position;
    logic signed [31:0] shaft_speed;
  } ppid_in_t;

  typedef struct packed {
    logic signed [31:0] current_target;
    logic               loop_ran;
  } ppid_out_t;

  typedef struct packed {
    logic [31:0]        kp;
    logic [31:0]        ki_dt;
    logic [31:0]        kd;
    logic [31:0]        kt_dt;
    logic [30:0]        integral_limit;
    logic signed [31:0] output_min;
    logic signed [31:0] output_max;
    logic [7:0]         loop_divider;
  } ppid_cfg_t;

  typedef enum logic [2:0] {
    CFG_KP        = 3'd0,
    CFG_KI_DT     = 3'd1,
    CFG_KD        = 3'd2,
    CFG_KT_DT     = 3'd3,
    CFG_INT_LIMIT = 3'd4,
    CFG_OUT_MIN   = 3'd5,
    CFG_OUT_MAX   = 3'd6,
    CFG_DIVIDER   = 3'd7
  } ppid_cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OMEGA,
    ST_P,
    ST_D,
    ST_KI,
    ST_KT,
    ST_INC,
    ST_DIV,
    ST_INT,
    ST_SUM,
    ST_OUT,
    ST_DONE
  } ppid_state_e;

  // saturate a 34 bit signed sum to signed 32 bits
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  function automatic logic signed [33:0] sx34(input logic signed [31:0] v);
    return {{2{v[31]}}, v};
  endfunction

endpackage

[sv/ppid_mul.sv]
// shared multiply unit: unsigned q16.16 gain times signed q16.16 value,
// floor shift by 16, saturated to 32 bits; depends on ppid_pkg
module ppid_mul
  import ppid_pkg::*;
(
  input  logic               clk_i,
  input  logic [31:0]        gain_i,
  input  logic signed [31:0] value_i,
  output logic signed [31:0] res_o
);

  logic signed [64:0] prod_d;
  logic signed [64:0] prod_q;
  logic signed [48:0] shifted;
  logic signed [33:0] shifted_34;

  assign prod_d = $signed({1'b0, gain_i}) * value_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // arithmetic shift keeps the floor rounding
  assign shifted = prod_q[64:16];

  always_comb begin
    if (shifted[48:31] == {18{1'b0}} || shifted[48:31] == {18{1'b1}}) begin
      shifted_34 = sx34(shifted[31:0]);
    end else if (shifted[48]) begin
      shifted_34 = sx34(32'sh8000_0000);
    end else begin
      shifted_34 = sx34(32'sh7fff_ffff);
    end
    res_o = sat34(shifted_34);
  end

endmodule

[sv/ppid_core.sv]
// sequencer and datapath of the pid step around one shared multiplier
// depends on ppid_pkg and ppid_mul
module ppid_core
  import ppid_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ppid_cfg_t cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ppid_in_t  in_data_i,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output ppid_out_t res_data_o
);

  ppid_state_e state_q, state_d;

  ppid_in_t           in_q;
  logic [7:0]         tick_q;
  logic               ran_q;
  logic signed [31:0] err_q, omega_q, p_q, d_q, t_q, sum_q;
  logic signed [31:0] integ_q, windup_q, held_q;

  logic [31:0]        mul_gain;
  logic signed [31:0] mul_value;
  logic signed [31:0] mul_res;

  logic               accept;
  logic [7:0]         tick_nx;
  logic               run;
  logic signed [31:0] lim_pos, lim_neg, integ_sat, out_clamp;

  ppid_mul u_mul (
    .clk_i  (clk_i),
    .gain_i (mul_gain),
    .value_i(mul_value),
    .res_o  (mul_res)
  );

  assign accept  = in_valid_i && in_ready_o;
  assign tick_nx = tick_q + 8'd1;
  assign run     = (tick_nx >= cfg_i.loop_divider);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = run ? ST_OMEGA : ST_DONE;
      ST_OMEGA: state_d = ST_P;
      ST_P:     state_d = ST_D;
      ST_D:     state_d = ST_KI;
      ST_KI:    state_d = ST_KT;
      ST_KT:    state_d = ST_INC;
      ST_INC:   state_d = ST_DIV;
      ST_DIV:   state_d = ST_INT;
      ST_INT:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_OUT;
      ST_OUT:   state_d = ST_DONE;
      ST_DONE:  if (res_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs and multiplier operand select
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mul_gain    = RadPerRpm;
    mul_value   = in_q.shaft_speed;
    unique case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_OMEGA: begin
        mul_gain  = RadPerRpm;
        mul_value = in_q.shaft_speed;
      end
      ST_P: begin
        mul_gain  = cfg_i.kp;
        mul_value = err_q;
      end
      ST_D: begin
        mul_gain  = cfg_i.kd;
        mul_value = -omega_q;
      end
      ST_KI: begin
        mul_gain  = cfg_i.ki_dt;
        mul_value = p_q;
      end
      ST_KT: begin
        mul_gain  = cfg_i.kt_dt;
        mul_value = windup_q;
      end
      ST_DIV: begin
        // div << 16 turns the q16.16 product into a plain integer scale
        mul_gain  = {8'd0, cfg_i.loop_divider, 16'd0};
        mul_value = t_q;
      end
      ST_DONE:  res_valid_o = 1'b1;
      default:  ;
    endcase
  end

  assign res_data_o.current_target = held_q;
  assign res_data_o.loop_ran       = ran_q;

  // integral clamp and output clamp
  assign lim_pos   = $signed({1'b0, cfg_i.integral_limit});
  assign lim_neg   = -lim_pos;
  assign integ_sat = sat34(sx34(integ_q) + sx34(mul_res));

  always_comb begin
    if (sum_q < cfg_i.output_min) begin
      out_clamp = cfg_i.output_min;
    end else if (sum_q > cfg_i.output_max) begin
      out_clamp = cfg_i.output_max;
    end else begin
      out_clamp = sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      tick_q   <= 8'd0;
      ran_q    <= 1'b0;
      integ_q  <= '0;
      windup_q <= '0;
      held_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        tick_q <= run ? 8'd0 : tick_nx;
        ran_q  <= run;
      end
      if (state_q == ST_INT) begin
        if (integ_sat > lim_pos) begin
          integ_q <= lim_pos;
        end else if (integ_sat < lim_neg) begin
          integ_q <= lim_neg;
        end else begin
          integ_q <= integ_sat;
        end
      end
      if (state_q == ST_OUT) begin
        held_q   <= out_clamp;
        windup_q <= sat34(sx34(sum_q) - sx34(out_clamp));
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
    unique case (state_q)
      ST_OMEGA: err_q   <= sat34(sx34(in_q.pos_setpoint) - sx34(in_q.measured_position));
      ST_P:     omega_q <= mul_res;
      ST_D:     p_q     <= mul_res;
      ST_KI:    d_q     <= mul_res;
      ST_KT:    t_q     <= mul_res;
      ST_INC:   t_q     <= sat34(sx34(t_q) - sx34(mul_res));
      ST_SUM:   sum_q   <= sat34(sx34(p_q) + sx34(integ_q) + sx34(d_q));
      default:  ;
    endcase
  end

endmodule

[sv/position_pid_backcalc_antiwindup.sv]
// top level of the position pid with back-calculation anti-windup
// holds the configuration registers and the result register; depends on
// ppid_pkg and ppid_core
//
//   channel | signals                                  | item
//   --------+------------------------------------------+------------------------------
//   in      | in_valid_i / in_ready_o / in_data_i      | one control tick
//   out     | out_valid_o / out_ready_i / out_data_o   | current target and loop flag
//   cfg     | cfg_we_i / cfg_index_i / cfg_data_i      | one register write, no wait
//
// a tick on which the loop runs passes the omega, p, d, ki, kt, inc, div,
// int, sum and out steps into done, a held tick goes from idle straight to
// done; done waits until the result register can load; the shared multiplier
// is issued in the omega, p, d, ki, kt and div steps, one issue per step
// one item is in work at a time; in_ready_o is high while the sequencer idles,
// so the next item can enter while the last result still waits in out
// reset clears the gains, limits, integral, windup error and held output;
// loop_divider resets to 1
module position_pid_backcalc_antiwindup
  import ppid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ppid_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ppid_out_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  ppid_cfg_t cfg_q;
  logic      res_valid;
  logic      res_ready;
  ppid_out_t res_data;
  logic      out_valid_q;
  ppid_out_t out_data_q;

  // configuration registers: the user must write them only while no item is in work; the block leaves this to the user
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp             <= '0;
      cfg_q.ki_dt          <= '0;
      cfg_q.kd             <= '0;
      cfg_q.kt_dt          <= '0;
      cfg_q.integral_limit <= '0;
      cfg_q.output_min     <= '0;
      cfg_q.output_max     <= '0;
      cfg_q.loop_divider   <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (ppid_cfg_idx_e'(cfg_index_i))
        CFG_KP:        cfg_q.kp             <= cfg_data_i;
        CFG_KI_DT:     cfg_q.ki_dt          <= cfg_data_i;
        CFG_KD:        cfg_q.kd             <= cfg_data_i;
        CFG_KT_DT:     cfg_q.kt_dt          <= cfg_data_i;
        CFG_INT_LIMIT: cfg_q.integral_limit <= cfg_data_i[30:0];
        CFG_OUT_MIN:   cfg_q.output_min     <= cfg_data_i;
        CFG_OUT_MAX:   cfg_q.output_max     <= cfg_data_i;
        CFG_DIVIDER:   cfg_q.loop_divider   <= cfg_data_i[7:0];
        default:       ;
      endcase
    end
  end

  // sequencer with the shared multiplier
  ppid_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_data_o (res_data)
  );

  // result register: loads when empty or when its item leaves this cycle
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_data_q <= res_data;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[tb/sv/tb_position_pid_backcalc_antiwindup.sv]
// testbench for position_pid_backcalc_antiwindup: directed and random control ticks
// checked against a q16.16 predictor of the pid; depends on ppid_pkg and the block rtl
`timescale 1ns / 100ps

module tb_position_pid_backcalc_antiwindup;
  import ppid_pkg::*;

  // q16.16 helpers for the directed items
  localparam logic signed [31:0] QOne = 32'sh0001_0000;
  localparam logic signed [31:0] QMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] QMin = 32'sh8000_0000;
  localparam logic [30:0]        LimMax = 31'h7fff_ffff;
  // 2*pi/60 in q16.16, rpm to rad/s
  localparam logic [31:0]        RpmToRadS = 32'd6863;
  localparam longint             SatHi = 64'sd2147483647;
  localparam longint             SatLo = -64'sd2147483648;

  // after the last result, wait until any running tick is done and the block is idle
  localparam int SettleCycles = 16;
  // long receiver hold-off used to back the block up
  localparam int HoldCycles   = 300;
  // cycles without any accepted item before the run is declared hung
  localparam int QuietLimit   = 5000;
  localparam int RandomItems  = 135;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  ppid_in_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  ppid_out_t   out_data_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  position_pid_backcalc_antiwindup dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: own copy of the registers and of the loop state
  // ---------------------------------------------------------------------------
  ppid_cfg_t          cfg_model;
  logic [7:0]         tick_div_cnt;
  logic signed [31:0] integ_acc;
  logic signed [31:0] windup_err;
  logic signed [31:0] held_out;

  // current targets still to come out of the block, oldest first
  ppid_out_t due_outputs[$];

  int mismatches;
  int results_seen;

  // sender and receiver idling controls, set by the tests
  bit tx_gappy;
  int burst_left;
  bit rx_stall;
  bit hold_req;

  // saturate a 64 bit value to signed 32 bits
  function automatic logic signed [31:0] clip32(longint v);
    if (v > SatHi) return QMax;
    if (v < SatLo) return QMin;
    return v[31:0];
  endfunction

  // unsigned q16.16 gain times signed q16.16 value, floor on the shift, saturated
  function automatic logic signed [31:0] gain_mul(logic [31:0] gain, logic signed [31:0] x);
    longint g64;
    longint x64;
    longint prod;
    g64 = longint'({32'd0, gain});
    x64 = longint'($signed(x));
    prod = g64 * x64;
    // arithmetic shift of a signed value rounds toward minus infinity
    return clip32(prod >>> 16);
  endfunction

  // one control tick through the predictor; updates the loop state
  function automatic ppid_out_t predict_tick(ppid_in_t t);
    ppid_out_t          r;
    logic signed [31:0] err;
    logic signed [31:0] omega;
    logic signed [31:0] neg_omega;
    logic signed [31:0] p_term;
    logic signed [31:0] d_term;
    logic signed [31:0] inc;
    logic signed [31:0] lim;
    logic signed [31:0] sum;
    longint             div64;
    tick_div_cnt = tick_div_cnt + 8'd1;
    r.loop_ran = 1'b0;
    // a divider of zero lets the loop run on every tick; a lowered divider
    // fires as soon as the count has reached it
    if (tick_div_cnt >= cfg_model.loop_divider) begin
      tick_div_cnt = '0;
      r.loop_ran = 1'b1;
      err = clip32(longint'($signed(t.pos_setpoint))
                   - longint'($signed(t.measured_position)));
      omega = gain_mul(RpmToRadS, t.shaft_speed);
      neg_omega = -omega;
      p_term = gain_mul(cfg_model.kp, err);
      d_term = gain_mul(cfg_model.kd, neg_omega);
      // integral step, with the clamp excess of the last run fed back
      inc = clip32(longint'(gain_mul(cfg_model.ki_dt, p_term))
                   - longint'(gain_mul(cfg_model.kt_dt, windup_err)));
      div64 = longint'({56'd0, cfg_model.loop_divider});
      inc = clip32(longint'(inc) * div64);
      integ_acc = clip32(longint'(integ_acc) + longint'(inc));
      lim = $signed({1'b0, cfg_model.integral_limit});
      if (integ_acc > lim) integ_acc = lim;
      if (integ_acc < -lim) integ_acc = -lim;
      sum = clip32(longint'(p_term) + longint'(integ_acc) + longint'(d_term));
      // inverted limits: below the minimum wins, everything else above the
      // maximum gives the maximum
      if (sum < $signed(cfg_model.output_min)) held_out = cfg_model.output_min;
      else if (sum > $signed(cfg_model.output_max)) held_out = cfg_model.output_max;
      else held_out = sum;
      windup_err = clip32(longint'(sum) - longint'(held_out));
    end
    r.current_target = held_out;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offer one tick, wait for it to be taken, then maybe open a gap
  task automatic send_tick(ppid_in_t t);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    due_outputs.push_back(predict_tick(t));
    if (tx_gappy) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 15);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  // write enable is left high so back-to-back writes need no extra step
  task automatic put_reg(ppid_cfg_idx_e idx, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  // write all eight registers; unused upper bits carry junk that the block drops
  task automatic apply_config(ppid_cfg_t c);
    logic        junk_bit;
    logic [23:0] junk_hi;
    junk_bit = 1'($urandom_range(0, 1));
    junk_hi  = 24'($urandom());
    put_reg(CFG_KP, c.kp);
    put_reg(CFG_KI_DT, c.ki_dt);
    put_reg(CFG_KD, c.kd);
    put_reg(CFG_KT_DT, c.kt_dt);
    put_reg(CFG_INT_LIMIT, {junk_bit, c.integral_limit});
    put_reg(CFG_OUT_MIN, c.output_min);
    put_reg(CFG_OUT_MAX, c.output_max);
    put_reg(CFG_DIVIDER, {junk_hi, c.loop_divider});
    cfg_we_i <= 1'b0;
    cfg_model = c;
  endtask

  // stop offering, let every expected result arrive, then let the block settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // receiver: always ready, a random run-length pattern, or a long hold-off
  int rx_run;
  bit rx_on;
  int hold_left;
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
      out_ready_i <= 1'b0;
    end else if (!rx_stall) begin
      out_ready_i <= 1'b1;
    end else begin
      if (rx_run == 0) begin
        rx_on  = !rx_on;
        rx_run = rx_on ? $urandom_range(1, 10) : $urandom_range(1, 6);
      end else begin
        rx_run = rx_run - 1;
      end
      out_ready_i <= rx_on;
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d, %s: got %h, expected %h",
             results_seen, what, got, want);
    mismatches++;
  endtask

  // outputs are sampled at the edge, before the block updates them
  always @(posedge clk_i) begin
    ppid_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_outputs.size() == 0) begin
        report_mismatch("item with nothing expected", out_data_o.current_target, '0);
      end else begin
        want = due_outputs.pop_front();
        if (out_data_o.current_target !== want.current_target)
          report_mismatch("current_target", out_data_o.current_target, want.current_target);
        if (out_data_o.loop_ran !== want.loop_ran)
          report_mismatch("loop_ran", 32'(out_data_o.loop_ran), 32'(want.loop_ran));
      end
      results_seen++;
    end
  end

  // hang detector: any accepted item or register write counts as progress
  int quiet_cycles;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic ppid_in_t mk_tick(logic [31:0] tgt, logic [31:0] pos, logic [31:0] spd);
    ppid_in_t t;
    t.pos_setpoint      = tgt;
    t.measured_position = pos;
    t.shaft_speed       = spd;
    return t;
  endfunction

  // zero gains, full output range, loop every tick
  function automatic ppid_cfg_t base_cfg();
    ppid_cfg_t c;
    c = '0;
    c.output_min   = QMin;
    c.output_max   = QMax;
    c.loop_divider = 8'd1;
    return c;
  endfunction

  // value spread evenly over [-span, span]
  function automatic logic signed [31:0] near_zero(int unsigned span);
    logic signed [31:0] v;
    v = $urandom_range(0, 2 * span);
    return v - $signed(span);
  endfunction

  // gains mostly around unity, sometimes anywhere in the full range
  function automatic logic [31:0] pick_gain();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return $urandom_range(0, 32'h0004_0000);
  endfunction

  function automatic ppid_cfg_t random_cfg();
    ppid_cfg_t          c;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    c.kp    = pick_gain();
    c.ki_dt = pick_gain();
    c.kd    = pick_gain();
    c.kt_dt = pick_gain();
    c.integral_limit = ($urandom_range(0, 7) == 0) ? 31'($urandom())
                                                   : 31'($urandom_range(0, 32'h0020_0000));
    lo = -$signed(32'($urandom_range(0, 32'h0010_0000)));
    hi = $urandom_range(0, 32'h0010_0000);
    case ($urandom_range(0, 7))
      0: begin
        c.output_min = $urandom();
        c.output_max = $urandom();
      end
      1: begin
        c.output_min = hi;
        c.output_max = lo;
      end
      default: begin
        c.output_min = lo;
        c.output_max = hi;
      end
    endcase
    case ($urandom_range(0, 9))
      0: c.loop_divider = 8'd0;
      1: c.loop_divider = 8'd255;
      default: c.loop_divider = 8'($urandom_range(1, 6));
    endcase
    return c;
  endfunction

  // mostly a target with the measured position close behind it,
  // sometimes raw bits everywhere
  function automatic ppid_in_t random_tick();
    ppid_in_t t;
    if ($urandom_range(0, 3) == 0) begin
      t.pos_setpoint      = $urandom();
      t.measured_position = $urandom();
      t.shaft_speed       = $urandom();
    end else begin
      t.pos_setpoint      = near_zero(32'h0010_0000);
      t.measured_position = t.pos_setpoint + near_zero(32'h0002_0000);
      t.shaft_speed       = near_zero(32'h0040_0000);
    end
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: zero gains and a [0, 0] output clamp give zero on every tick
  task automatic test_after_reset();
    send_tick(mk_tick(QOne, 0, QOne));
    send_tick(mk_tick(QMax, QMin, QMax));
    wait_drained();
  endtask

  // proportional path: error saturation both ways and floor rounding
  task automatic test_proportional();
    ppid_cfg_t c;
    c = base_cfg();
    c.kp = 32'h0001_8000;
    apply_config(c);
    send_tick(mk_tick(QMax, QMin, 0));
    send_tick(mk_tick(QMin, QMax, 0));
    // error of one lsb below zero times 1.5 rounds down to -2
    send_tick(mk_tick(0, 1, 0));
    send_tick(mk_tick(3 * QOne, QOne, 0));
    wait_drained();
  endtask

  // derivative path with the largest gain and the extreme speeds
  task automatic test_derivative();
    ppid_cfg_t c;
    c = base_cfg();
    c.kd = 32'hffff_ffff;
    apply_config(c);
    send_tick(mk_tick(0, 0, QMax));
    send_tick(mk_tick(0, 0, QMin));
    send_tick(mk_tick(0, 0, 32'sd1));
    wait_drained();
  endtask

  // integral grows by ki*p and is clamped to the symmetric limit
  task automatic test_integral_clamp();
    ppid_cfg_t c;
    c = base_cfg();
    c.kp = QOne;
    c.ki_dt = 32'h0000_8000;
    c.integral_limit = 31'h0003_0000;
    apply_config(c);
    send_tick(mk_tick(4 * QOne, 0, 0));
    send_tick(mk_tick(4 * QOne, 0, 0));
    send_tick(mk_tick(4 * QOne, 0, 0));
    send_tick(mk_tick(-8 * QOne, 0, 0));
    wait_drained();
  endtask

  // narrow output clamp so the removed excess feeds back into the integral
  task automatic test_back_calc();
    ppid_cfg_t c;
    c = base_cfg();
    c.kp = 4 * QOne;
    c.ki_dt = 32'h0000_4000;
    c.kt_dt = QOne;
    c.integral_limit = LimMax;
    c.output_min = -QOne;
    c.output_max = QOne;
    apply_config(c);
    send_tick(mk_tick(2 * QOne, 0, 0));
    send_tick(mk_tick(2 * QOne, 0, 0));
    send_tick(mk_tick(-2 * QOne, 0, 0));
    wait_drained();
  endtask

  // divider zero: loop on every tick, integral step scaled to nothing
  task automatic test_divider_zero();
    ppid_cfg_t c;
    c = base_cfg();
    c.kp = QOne;
    c.ki_dt = QOne;
    c.integral_limit = LimMax;
    c.loop_divider = 8'd0;
    apply_config(c);
    send_tick(mk_tick(QOne, 0, 0));
    send_tick(mk_tick(QOne, 0, 0));
    wait_drained();
  endtask

  // three held ticks with divider 5, then the divider drops below the count
  task automatic test_divider_lowered();
    ppid_cfg_t c;
    c = base_cfg();
    c.kp = QOne;
    c.loop_divider = 8'd5;
    apply_config(c);
    send_tick(mk_tick(QOne, 0, 0));
    send_tick(mk_tick(2 * QOne, 0, 0));
    send_tick(mk_tick(3 * QOne, 0, 0));
    wait_drained();
    c.loop_divider = 8'd2;
    apply_config(c);
    send_tick(mk_tick(-QOne, 0, 0));
    wait_drained();
  endtask

  // output_min above output_max
  task automatic test_inverted_limits();
    ppid_cfg_t c;
    c = base_cfg();
    c.kp = QOne;
    c.output_min = 2 * QOne;
    c.output_max = -2 * QOne;
    apply_config(c);
    send_tick(mk_tick(-5 * QOne, 0, 0));
    send_tick(mk_tick(0, 0, 0));
    send_tick(mk_tick(5 * QOne, 0, 0));
    wait_drained();
  endtask

  // receiver holds off for a long stretch while ticks keep coming back to back
  task automatic test_backpressure();
    tx_gappy = 1'b0;
    rx_stall = 1'b0;
    apply_config(random_cfg());
    hold_req = 1'b1;
    repeat (60) send_tick(random_tick());
    wait_drained();
  endtask

  // several register settings, the extremes first, with random traffic each
  task automatic test_random_traffic();
    ppid_cfg_t c;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin
          c = base_cfg();
          c.kp = 32'hffff_ffff;
          c.ki_dt = 32'hffff_ffff;
          c.kd = 32'hffff_ffff;
          c.kt_dt = 32'hffff_ffff;
          c.integral_limit = LimMax;
        end
        1: begin
          c = '0;
          c.output_min = QMax;
          c.output_max = QMin;
          c.loop_divider = 8'd255;
        end
        default: c = random_cfg();
      endcase
      // phase 0 runs with no idling on either side
      tx_gappy = phase[0];
      rx_stall = (phase >= 2) && (phase != 4);
      apply_config(c);
      repeat (RandomItems) send_tick(random_tick());
      wait_drained();
    end
  endtask

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    tx_gappy    = 1'b0;
    burst_left  = 0;
    rx_stall    = 1'b0;
    hold_req    = 1'b0;
    hold_left   = 0;
    rx_run      = 0;
    rx_on       = 1'b0;
    mismatches  = 0;
    results_seen = 0;
    quiet_cycles = 0;
    // predictor state after reset
    cfg_model    = '0;
    cfg_model.loop_divider = 8'd1;
    tick_div_cnt = '0;
    integ_acc    = '0;
    windup_err   = '0;
    held_out     = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_after_reset();
    test_proportional();
    test_derivative();
    test_integral_clamp();
    test_back_calc();
    test_divider_zero();
    test_divider_lowered();
    test_inverted_limits();
    test_backpressure();
    test_random_traffic();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
